@@ rtl/asru_pkg.sv @@
// shared types, codes and defaults for the active set swap-remove unit
package asru_pkg;

  // default sizes
  localparam int DEF_NUM_ENTRIES = 512;
  localparam int DEF_MAX_ACTIVE  = 512;

  // width used for range compares, covers every legal size
  localparam int CMP_W = 16;

  // width of an entry number as stored in the active list
  localparam int ENTRY_W = 9;

  // operation codes
  typedef enum logic [1:0] {
    OP_ACTIVATE   = 2'd0,
    OP_DEACTIVATE = 2'd1,
    OP_READ       = 2'd2,
    OP_NONE       = 2'd3
  } op_t;

  // status codes
  localparam logic [2:0] ST_CHANGED  = 3'd0;
  localparam logic [2:0] ST_NOCHANGE = 3'd1;
  localparam logic [2:0] ST_NEEDROOT = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RANGE    = 3'd4;

  // request item
  typedef struct packed {
    op_t                op;
    logic [ENTRY_W-1:0] entry_number;
    logic               root_only;
    logic [8:0]         slot_index;
  } req_t;

  // result item
  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         active_count;
    logic [ENTRY_W-1:0] slot_entry;
    logic [9:0]         entry_position;
  } rsp_t;

endpackage

@@ rtl/asru_ram.sv @@
// generic single-port synchronous ram with registered read
module asru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read through a registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/asru_ctrl.sv @@
// sequencer and datapath over the position map and the active list
module asru_ctrl import asru_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int MAX_ACTIVE  = DEF_MAX_ACTIVE
) (
  input  logic clk,
  input  logic rst,
  input  logic caller_is_root,
  input  logic req_valid,
  input  req_t req,
  output logic req_stall,
  output logic res_valid,
  output rsp_t res,
  input  logic res_take
);

  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int LW = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
  localparam int PW = $clog2(MAX_ACTIVE + 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MOVE  = 6'b001000,
    S_CLR   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t             state, state_next;
  req_t               cur;
  logic [PW-1:0]      total, total_next;
  logic [LW-1:0]      idx, idx_next;
  logic [EW-1:0]      clr_cnt;
  rsp_t               res_next;

  // memory ports
  logic               p_we;
  logic [EW-1:0]      p_addr;
  logic [PW-1:0]      p_wd, p_rd;
  logic               l_we;
  logic [LW-1:0]      l_addr;
  logic [ENTRY_W-1:0] l_wd, l_rd;

  // decode helpers
  logic               ent_ok;
  logic [PW-1:0]      pos_cur, idx_w, last_w;
  logic               slot_ok, moved_ok;

  asru_ram #(.WIDTH(PW), .DEPTH(NUM_ENTRIES)) u_pos_ram (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd)
  );

  asru_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ACTIVE)) u_list_ram (
    .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wd), .rdata(l_rd)
  );

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  assign ent_ok   = CMP_W'(cur.entry_number) < CMP_W'(NUM_ENTRIES);
  assign pos_cur  = ent_ok ? p_rd : '0;
  assign idx_w    = pos_cur - PW'(1);
  assign last_w   = total - PW'(1);
  assign slot_ok  = (CMP_W'(cur.slot_index) < CMP_W'(total)) &&
                    (CMP_W'(cur.slot_index) < CMP_W'(MAX_ACTIVE));
  assign moved_ok = CMP_W'(l_rd) < CMP_W'(NUM_ENTRIES);

  // next state, memory accesses and result
  always_comb begin
    state_next = state;
    total_next = total;
    idx_next   = idx;
    res_next   = res;
    p_we       = 1'b0;
    p_addr     = EW'(cur.entry_number);
    p_wd       = '0;
    l_we       = 1'b0;
    l_addr     = LW'(cur.slot_index);
    l_wd       = cur.entry_number;
    unique case (state)
      S_CLEAR: begin
        p_we   = 1'b1;
        p_addr = clr_cnt;
        if (clr_cnt == EW'(NUM_ENTRIES - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        // issue reads straight from the incoming item
        p_addr = EW'(req.entry_number);
        l_addr = LW'(req.slot_index);
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_next.status         = ST_NOCHANGE;
        res_next.slot_entry     = '0;
        res_next.entry_position = 10'(pos_cur);
        state_next              = S_DONE;
        unique case (cur.op)
          OP_ACTIVATE: begin
            priority if (cur.root_only && !caller_is_root) begin
              res_next.status = ST_NEEDROOT;
            end else if (!ent_ok || pos_cur != '0) begin
              res_next.status = ST_NOCHANGE;
            end else if (CMP_W'(total) >= CMP_W'(MAX_ACTIVE)) begin
              res_next.status = ST_FULL;
            end else begin
              // append at the tail
              l_we   = 1'b1;
              l_addr = total[LW-1:0];
              l_wd   = cur.entry_number;
              p_we   = 1'b1;
              p_wd   = total + PW'(1);
              total_next              = total + PW'(1);
              res_next.status         = ST_CHANGED;
              res_next.entry_position = 10'(total + PW'(1));
            end
          end
          OP_DEACTIVATE: begin
            priority if (!ent_ok || pos_cur == '0 || total == '0) begin
              res_next.status = ST_NOCHANGE;
            end else if (idx_w > last_w) begin
              // stale position, just drop it
              p_we = 1'b1;
              res_next.status         = ST_NOCHANGE;
              res_next.entry_position = '0;
            end else if (idx_w == last_w) begin
              // removing the tail, nothing to move
              p_we = 1'b1;
              total_next              = last_w;
              res_next.status         = ST_CHANGED;
              res_next.entry_position = '0;
            end else begin
              // fetch the tail entry to move into the freed slot
              l_addr     = last_w[LW-1:0];
              idx_next   = idx_w[LW-1:0];
              total_next = last_w;
              res_next.status         = ST_CHANGED;
              res_next.entry_position = '0;
              state_next = S_MOVE;
            end
          end
          OP_READ: begin
            if (slot_ok) begin
              res_next.slot_entry = l_rd;
            end else begin
              res_next.status = ST_RANGE;
            end
          end
          default: begin
            res_next.status = ST_NOCHANGE;
          end
        endcase
        res_next.active_count = 10'(total_next);
      end
      S_MOVE: begin
        // moved entry goes to the freed slot, its position follows
        l_we   = 1'b1;
        l_addr = idx;
        l_wd   = l_rd;
        p_we   = moved_ok;
        p_addr = EW'(l_rd);
        p_wd   = PW'(idx) + PW'(1);
        state_next = S_CLR;
      end
      S_CLR: begin
        p_we       = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      total   <= '0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      total <= total_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + EW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      cur <= req;
    end
    idx <= idx_next;
    res <= res_next;
  end

endmodule

@@ rtl/active_set_swap_remove_unit.sv @@
// top level of the active set swap-remove unit
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_t  (op, entry, root flag, slot)
//  rsp      out        rsp_valid/rsp_stall  rsp_t  (status, count, slot entry, position)
//  cfg      in         cfg_valid/cfg_ready  caller_is_root bit
//
// activate, read, unused op and a tail or no-op deactivate run idle, exec and done;
// a deactivate that moves the tail adds move and clr, set by the single port of each ram.
// after reset a clearing pass writes every position map entry, with req stalled.
// one item is in work at a time; a finished result sits in the output register
// while the next item is accepted, and a stalled result holds the sequencer.
module active_set_swap_remove_unit import asru_pkg::*; #(
  parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int MAX_ACTIVE  = DEF_MAX_ACTIVE
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic caller_is_root;
  logic res_valid, res_take;
  rsp_t res;

  asru_ctrl #(.NUM_ENTRIES(NUM_ENTRIES), .MAX_ACTIVE(MAX_ACTIVE)) u_ctrl (
    .clk(clk), .rst(rst), .caller_is_root(caller_is_root),
    .req_valid(req_valid), .req(req), .req_stall(req_stall),
    .res_valid(res_valid), .res(res), .res_take(res_take)
  );

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      caller_is_root <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      caller_is_root <= cfg_data;
    end
  end

  // output register
  assign res_take = res_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

  // an accepted item keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("input accepted again right after an item");

  // count never exceeds the list size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (CMP_W'(rsp.active_count) <= CMP_W'(MAX_ACTIVE)))
    else $error("active count above list size");

  // out of range slot gives no entry
  a_range_no_entry: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_RANGE) |-> (rsp.slot_entry == '0))
    else $error("slot entry set on out of range read");

endmodule

@@ dv/active_set_swap_remove_unit_test.sv @@
// self-checking testbench for the active set swap-remove unit
module active_set_swap_remove_unit_test;
  import asru_pkg::*;

  localparam int NUM_E = DEF_NUM_ENTRIES;
  localparam int MAX_A = DEF_MAX_ACTIVE;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  // one row of the directed table: either a root-mode write or an item
  typedef struct packed {
    logic is_cfg;
    logic cfg_val;
    req_t stim;
    logic typed;
    rsp_t want;
  } tab_row_t;

  localparam rsp_t NO_RSP = '0;
  localparam int DIR_N = 23;
  localparam tab_row_t DIR_TAB [DIR_N] = '{
    // empty set: read, deactivate, refused root, unused op
    '{1'b0, 1'b0, '{OP_READ, 9'd0, 1'b0, 9'd0},
      1'b1, '{ST_RANGE, 10'd0, 9'd0, 10'd0}},
    '{1'b0, 1'b0, '{OP_DEACTIVATE, 9'd511, 1'b0, 9'd0},
      1'b1, '{ST_NOCHANGE, 10'd0, 9'd0, 10'd0}},
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd5, 1'b1, 9'd0},
      1'b1, '{ST_NEEDROOT, 10'd0, 9'd0, 10'd0}},
    '{1'b0, 1'b0, '{OP_NONE, 9'd0, 1'b1, 9'd511},
      1'b1, '{ST_NOCHANGE, 10'd0, 9'd0, 10'd0}},
    // fill a few slots, extremes of the entry range
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd0, 1'b0, 9'd0},
      1'b1, '{ST_CHANGED, 10'd1, 9'd0, 10'd1}},
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd511, 1'b0, 9'd0},
      1'b1, '{ST_CHANGED, 10'd2, 9'd0, 10'd2}},
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd511, 1'b0, 9'd0},
      1'b1, '{ST_NOCHANGE, 10'd2, 9'd0, 10'd2}},
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd300, 1'b0, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_READ, 9'd0, 1'b0, 9'd2}, 1'b0, NO_RSP},
    // slot just past the end and the highest slot
    '{1'b0, 1'b0, '{OP_READ, 9'd511, 1'b0, 9'd3},
      1'b1, '{ST_RANGE, 10'd3, 9'd0, 10'd2}},
    '{1'b0, 1'b0, '{OP_READ, 9'd0, 1'b0, 9'd511},
      1'b1, '{ST_RANGE, 10'd3, 9'd0, 10'd1}},
    // remove the head so the tail moves down
    '{1'b0, 1'b0, '{OP_DEACTIVATE, 9'd0, 1'b0, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_READ, 9'd300, 1'b0, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd0, 1'b1, 9'd0},
      1'b1, '{ST_NEEDROOT, 10'd2, 9'd0, 10'd0}},
    // root check comes before the already-active check
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd300, 1'b1, 9'd0}, 1'b0, NO_RSP},
    // tail removal, then removal of an inactive entry
    '{1'b0, 1'b0, '{OP_DEACTIVATE, 9'd511, 1'b0, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_DEACTIVATE, 9'd511, 1'b0, 9'd0}, 1'b0, NO_RSP},
    // root caller from here on
    '{1'b1, 1'b1, '0, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd7, 1'b1, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_ACTIVATE, 9'd511, 1'b1, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_DEACTIVATE, 9'd300, 1'b0, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_NONE, 9'd7, 1'b0, 9'd0}, 1'b0, NO_RSP},
    '{1'b0, 1'b0, '{OP_READ, 9'd0, 1'b0, 9'd0}, 1'b0, NO_RSP}
  };

  // dut ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  // predictor state: position map, dense list, live count, root mode
  logic [9:0] pos_map [NUM_E] = '{default: '0};
  logic [8:0] dense [MAX_A] = '{default: '0};
  int unsigned n_active = 0;
  logic root_mode = 1'b0;

  rsp_t pending_rsp [$];
  int err_cnt = 0;
  int rsp_seen = 0;

  // idle pacing for both sides and the long receiver hold
  int tx_left = 0;
  bit tx_calm = 1'b0;
  int tx_rush = 0;
  int rx_left = 0;
  bit rx_calm = 1'b0;
  int rx_wait = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  active_set_swap_remove_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // expected result of one item; updates the predicted set
  function automatic rsp_t advance_active_set(req_t r);
    rsp_t o;
    int unsigned e;
    int unsigned idx;
    int unsigned last;
    logic [8:0] moved;
    o = '0;
    o.status = ST_NOCHANGE;
    e = r.entry_number;
    case (r.op)
      OP_ACTIVATE: begin
        if (r.root_only && !root_mode) begin
          o.status = ST_NEEDROOT;
        end else if (pos_map[e] != 0) begin
          o.status = ST_NOCHANGE;
        end else if (n_active >= MAX_A) begin
          o.status = ST_FULL;
        end else begin
          dense[n_active] = r.entry_number;
          n_active++;
          pos_map[e] = 10'(n_active);
          o.status = ST_CHANGED;
        end
      end
      OP_DEACTIVATE: begin
        if (pos_map[e] != 0 && n_active != 0) begin
          idx = pos_map[e] - 1;
          last = n_active - 1;
          if (idx > last) begin
            pos_map[e] = '0;
          end else begin
            // swap the tail entry into the freed slot
            if (idx != last) begin
              moved = dense[last];
              dense[idx] = moved;
              pos_map[moved] = 10'(idx + 1);
            end
            dense[last] = '0;
            n_active = last;
            pos_map[e] = '0;
            o.status = ST_CHANGED;
          end
        end
      end
      OP_READ: begin
        if (r.slot_index < n_active) begin
          o.slot_entry = dense[r.slot_index];
        end else begin
          o.status = ST_RANGE;
        end
      end
      default: begin
      end
    endcase
    o.active_count = 10'(n_active);
    o.entry_position = pos_map[e];
    return o;
  endfunction

  // per-item wait, with calm stretches where nothing idles
  function automatic int draw_wait(inout int left, inout bit calm);
    if (left == 0) begin
      left = $urandom_range(10, 40);
      calm = ($urandom_range(0, 3) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // random item with op weights in percent; op none takes the rest
  function automatic req_t make_random_item(int unsigned w_act, int unsigned w_deact,
                                            int unsigned w_read);
    req_t r;
    int unsigned pick;
    int unsigned hi;
    pick = $urandom_range(0, 99);
    if (pick < w_act) r.op = OP_ACTIVATE;
    else if (pick < w_act + w_deact) r.op = OP_DEACTIVATE;
    else if (pick < w_act + w_deact + w_read) r.op = OP_READ;
    else r.op = OP_NONE;
    // half the time aim at an entry that is live
    if (n_active != 0 && $urandom_range(0, 1) == 1)
      r.entry_number = dense[$urandom_range(0, n_active - 1)];
    else
      r.entry_number = 9'($urandom_range(0, NUM_E - 1));
    r.root_only = 1'($urandom_range(0, 1));
    // mostly slots near the live range, sometimes anywhere
    hi = (n_active > MAX_A - 1) ? MAX_A - 1 : n_active;
    if ($urandom_range(0, 3) != 0)
      r.slot_index = 9'($urandom_range(0, hi));
    else
      r.slot_index = 9'($urandom_range(0, MAX_A - 1));
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_cnt++;
    $display("MISMATCH %s", msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d", rsp_seen, name, got, want));
  endtask

  // offer one item, wait for acceptance, then queue its expected result
  task automatic send_item(req_t r, logic typed, rsp_t want);
    int gap;
    rsp_t pred;
    if (tx_rush > 0) begin
      gap = 0;
      tx_rush--;
    end else begin
      gap = draw_wait(tx_left, tx_calm);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pred = advance_active_set(r);
    pending_rsp.push_back(typed ? want : pred);
  endtask

  // root-mode write, only once every result is back
  task automatic write_root(logic v);
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    root_mode = v;
  endtask

  // result side: accept, compare, then pick the next stall pattern
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      rsp_stall <= 1'b0;
      hold_seen = hold_seq;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (pending_rsp.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", rsp_seen));
        end else begin
          exp_rsp = pending_rsp.pop_front();
          check_field("status", rsp.status, exp_rsp.status);
          check_field("active_count", rsp.active_count, exp_rsp.active_count);
          check_field("slot_entry", rsp.slot_entry, exp_rsp.slot_entry);
          check_field("entry_position", rsp.entry_position, exp_rsp.entry_position);
        end
        rx_wait = draw_wait(rx_left, rx_calm);
      end
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    req_t item;
    int unsigned base;
    int unsigned k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].is_cfg) write_root(DIR_TAB[i].cfg_val);
      else send_item(DIR_TAB[i].stim, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    // mixed traffic with root caller; a long receiver hold in the middle
    for (int i = 0; i < 40; i++) begin
      if (i == 10) begin
        hold_seq <= hold_seq + 1;
        tx_rush = 25;
      end
      send_item(make_random_item(55, 20, 20), 1'b0, NO_RSP);
    end

    // non-root caller: fill the list up to its last slot
    write_root(1'b0);
    while (n_active < MAX_A) begin
      if ($urandom_range(0, 31) == 0) begin
        item = make_random_item(40, 5, 45);
      end else begin
        base = $urandom_range(0, NUM_E - 1);
        for (k = 0; k < NUM_E; k++)
          if (pos_map[(base + k) % NUM_E] == 0) break;
        item.op = OP_ACTIVATE;
        item.entry_number = 9'((base + k) % NUM_E);
        item.root_only = 1'b0;
        item.slot_index = 9'($urandom_range(0, MAX_A - 1));
      end
      send_item(item, 1'b0, NO_RSP);
    end
    // full list: reads up to the last slot, repeat and refused activations
    for (int i = 0; i < 10; i++)
      send_item(make_random_item(50, 0, 50), 1'b0, NO_RSP);

    // root caller again: mostly removals
    write_root(1'b1);
    for (int i = 0; i < 20; i++)
      send_item(make_random_item(20, 55, 20), 1'b0, NO_RSP);

    // drain and finish
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
